// ===== hdl/rpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants for the retransmit pending table.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int KEY_W     = 32;
  localparam int CLIENT_W  = 48;
  localparam int NOW_W     = 32;
  localparam int RC_W      = 4;
  localparam int TIMEOUT_W = 8;
  localparam int RETRY_W   = 3;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = TIMEOUT_W;

  localparam int ENTRY_W    = RC_W + CLIENT_W + KEY_W;
  localparam int IN_DATA_W  = KEY_W + CLIENT_W + NOW_W;
  localparam int OUT_DATA_W = KEY_W + CLIENT_W;

  localparam logic [RC_W-1:0]      RC_MAX          = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 8'd1;
  localparam logic [RETRY_W-1:0]   MAX_RETRY_RESET = 3'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESEND    = 3'd0,
    KIND_LOST      = 3'd1,
    KIND_ACKED     = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_STORED    = 3'd4,
    KIND_FULL      = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT     = 1'b0,
    REG_MAX_RETRIES = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_STORE = 1'b0,
    MODE_ACK   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_e;

  // verdict on one table entry
  typedef struct packed {
    logic            match;
    logic            lost;
    logic            resend;
    logic [RC_W-1:0] rc_next;
  } judge_t;

endpackage

// ===== hdl/retransmit_pending_table.sv =====
`timescale 1ns / 1ps
// Store: result registered the cycle after the item is accepted; stores are
//   taken back to back while the result output is not stalled. Acknowledge
//   over N entries: a read-evaluate-write loop on the single table RAM walks
//   each entry through ST_READ then ST_EVAL (held while the output is stalled);
//   no new item is taken until the walk ends. Reset: entry count cleared,
//   timeout 1, retry limit 2; table contents left undefined, need no clearing pass.
// ----------------------------------------------------------------------------
// retransmit_pending_table
// Arrival-ordered table of messages awaiting acknowledgment with timeout
// resend and retry-limit drop, compacted in place during each walk.
// ----------------------------------------------------------------------------
module retransmit_pending_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [rpt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rpt_pkg::CFG_W-1:0]         cfg_data_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rpt_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // key, client_address, now
  input  logic                              s_axis_tuser,  // mode
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // entry_key, entry_client
  output logic [rpt_pkg::KIND_W-1:0]        m_axis_tuser,  // kind
  output logic                              m_axis_tlast   // last
);
  import rpt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic          found_q, found_d;

  logic [KEY_W-1:0] key_q, key_d;
  logic [NOW_W-1:0] now_q, now_d;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [RETRY_W-1:0]   max_retries_q;

  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [CLIENT_W-1:0] out_client_q, out_client_d;
  logic                out_last_q, out_last_d;
  logic                out_load;
  logic                out_free;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [KEY_W-1:0]    in_key;
  logic [CLIENT_W-1:0] in_client;
  logic [NOW_W-1:0]    in_now;

  logic [KEY_W-1:0]    ent_key;
  logic [CLIENT_W-1:0] ent_client;
  logic [RC_W-1:0]     ent_rc;
  judge_t              judge;
  logic                emit;

  assign in_key    = s_axis_tdata[KEY_W-1:0];
  assign in_client = s_axis_tdata[KEY_W +: CLIENT_W];
  assign in_now    = s_axis_tdata[KEY_W + CLIENT_W +: NOW_W];

  assign ent_key    = ram_rdata[KEY_W-1:0];
  assign ent_client = ram_rdata[KEY_W +: CLIENT_W];
  assign ent_rc     = ram_rdata[KEY_W + CLIENT_W +: RC_W];

  assign out_free = !out_valid_q || m_axis_tready;

  rpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_q[IW-1:0]),
    .rdata_o(ram_rdata)
  );

  rpt_judge u_judge (
    .entry_key_i  (ent_key),
    .entry_rc_i   (ent_rc),
    .search_key_i (key_q),
    .now_i        (now_q),
    .timeout_i    (timeout_q),
    .max_retries_i(max_retries_q),
    .judge_o      (judge)
  );

  assign emit = !found_q && (judge.match || judge.lost || judge.resend);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_d          = rd_q;
    wr_d          = wr_q;
    found_d       = found_q;
    key_d         = key_q;
    now_d         = now_q;
    out_load      = 1'b0;
    out_kind_d    = out_kind_q;
    out_key_d     = out_key_q;
    out_client_d  = out_client_q;
    out_last_d    = out_last_q;
    ram_we        = 1'b0;
    ram_waddr     = wr_q[IW-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (s_axis_tvalid && out_free) begin
          if (s_axis_tuser == MODE_STORE) begin
            out_load     = 1'b1;
            out_key_d    = in_key;
            out_client_d = in_client;
            out_last_d   = 1'b1;
            if (count_q == FULL_COUNT) begin
              out_kind_d = KIND_FULL;
            end else begin
              out_kind_d = KIND_STORED;
              ram_we     = 1'b1;
              ram_waddr  = count_q[IW-1:0];
              ram_wdata  = {{RC_W{1'b0}}, in_client, in_key};
              count_d    = count_q + 1'b1;
            end
          end else begin
            key_d   = in_key;
            now_d   = in_now;
            rd_d    = '0;
            wr_d    = '0;
            found_d = 1'b0;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (rd_q == count_q) begin
          state_d = ST_FINISH;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold the entry until the output register has room
        if (!emit || out_free) begin
          rd_d    = rd_q + 1'b1;
          state_d = ST_READ;
          out_key_d    = ent_key;
          out_client_d = ent_client;
          out_last_d   = 1'b0;
          if (found_q) begin
            ram_we = 1'b1;
            wr_d   = wr_q + 1'b1;
          end else if (judge.match) begin
            out_load   = 1'b1;
            out_kind_d = KIND_ACKED;
            out_last_d = 1'b1;
            found_d    = 1'b1;
          end else if (judge.lost) begin
            out_load   = 1'b1;
            out_kind_d = KIND_LOST;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {(judge.resend ? judge.rc_next : ent_rc), ent_client, ent_key};
            wr_d      = wr_q + 1'b1;
            if (judge.resend) begin
              out_load   = 1'b1;
              out_kind_d = KIND_RESEND;
            end
          end
        end
      end
      ST_FINISH: begin
        if (found_q) begin
          count_d = wr_q;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = KIND_NOT_FOUND;
          out_key_d    = key_q;
          out_client_d = '0;
          out_last_d   = 1'b1;
          count_d      = wr_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    now_q <= now_d;
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_key_q    <= out_key_d;
      out_client_q <= out_client_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TIMEOUT_RESET;
      max_retries_q <= MAX_RETRY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIMEOUT:     timeout_q     <= cfg_data_i;
        REG_MAX_RETRIES: max_retries_q <= cfg_data_i[RETRY_W-1:0];
        default: begin
          timeout_q <= timeout_q;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_client_q, out_key_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/rpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rpt_judge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_judge
// Entry evaluator shared by every step of an acknowledge walk: key compare,
// retry limit compare, wrap-around age compare and saturating retry count step.
// ----------------------------------------------------------------------------
module rpt_judge (
  input  logic [rpt_pkg::KEY_W-1:0]     entry_key_i,
  input  logic [rpt_pkg::RC_W-1:0]      entry_rc_i,
  input  logic [rpt_pkg::KEY_W-1:0]     search_key_i,
  input  logic [rpt_pkg::NOW_W-1:0]     now_i,
  input  logic [rpt_pkg::TIMEOUT_W-1:0] timeout_i,
  input  logic [rpt_pkg::RETRY_W-1:0]   max_retries_i,
  output rpt_pkg::judge_t               judge_o
);
  import rpt_pkg::*;

  logic [KEY_W-1:0] age;

  // age wraps modulo 2^32
  assign age = now_i - entry_key_i;

  always_comb begin
    judge_o.match   = (entry_key_i == search_key_i);
    judge_o.lost    = (entry_rc_i > {{(RC_W - RETRY_W){1'b0}}, max_retries_i});
    judge_o.resend  = (age > {{(KEY_W - TIMEOUT_W){1'b0}}, timeout_i});
    judge_o.rc_next = (entry_rc_i == RC_MAX) ? entry_rc_i : entry_rc_i + 1'b1;
  end

endmodule

// ===== hdl/rpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_checker
// Port-level checks for the retransmit pending table, bound to the top level.
// ----------------------------------------------------------------------------
module rpt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [rpt_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                           m_axis_tlast
);
  import rpt_pkg::*;

  // stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  // an input is taken only when the result slot has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken while result slot blocked");

  // a store answers next cycle with stored or full, echoing key and client
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_STORE) |=>
      m_axis_tvalid && m_axis_tlast &&
      (m_axis_tuser == KIND_STORED || m_axis_tuser == KIND_FULL) &&
      (m_axis_tdata == $past(s_axis_tdata[OUT_DATA_W-1:0])))
    else $error("store result wrong");

  // an acknowledge holds off input in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_ACK) |=> !s_axis_tready)
    else $error("acknowledge walk did not hold off input");

  // non-final results are only resend or lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tuser == KIND_RESEND || m_axis_tuser == KIND_LOST))
    else $error("bad kind on non-final result");

endmodule

bind retransmit_pending_table rpt_checker u_rpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
